// ----- rtl/core/assert_macros.svh -----
// assertion helpers used by the queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- rtl/core/lcdseq_pkg.sv -----
package lcdseq_pkg;

  // timing and sizing constants
  localparam int STARTUP_WAIT_MS = 50;
  localparam int PULSE_MS        = 1;
  localparam int GLYPH_ROWS      = 8;
  localparam int OPS_MAX         = 6;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0] STARTUP_HOLD = 6'(STARTUP_WAIT_MS);
  localparam logic [5:0] PULSE_HOLD   = 6'(PULSE_MS);
  localparam logic [5:0] CLEAR_HOLD   = 6'(PULSE_MS + 1);

  // request modes
  localparam logic [2:0] MODE_INIT  = 3'd0;
  localparam logic [2:0] MODE_CHAR  = 3'd1;
  localparam logic [2:0] MODE_CLEAR = 3'd2;
  localparam logic [2:0] MODE_GOTO  = 3'd3;
  localparam logic [2:0] MODE_GLYPH = 3'd4;

  // instruction bytes
  localparam logic [7:0] CMD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0c;
  localparam logic [7:0] CMD_HOME_4BIT = 8'h02;
  localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_LINE0     = 8'h80;
  localparam logic [7:0] CMD_LINE1     = 8'hc0;
  localparam logic [7:0] CMD_LINE2     = 8'h94;
  localparam logic [7:0] CMD_LINE3     = 8'hd4;
  localparam logic [7:0] CMD_CGRAM     = 8'h40;

  localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] char_code;
    logic [2:0] line;
    logic [5:0] column;
    logic [2:0] glyph_slot;
    logic [2:0] glyph_row;
    logic [7:0] row_bits;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_value;
    logic       enable;
    logic [5:0] hold_ms;
    logic       last;
  } phase_t;

  // one bus operation: the startup wait or one byte write
  typedef struct packed {
    logic       is_wait;
    logic       rs;
    logic [7:0] data;
    logic       extra;
    logic       fin;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic op_t byte_op(input logic rs, input logic [7:0] data,
                                  input logic extra);
    op_t o;
    o.is_wait = 1'b0;
    o.rs      = rs;
    o.data    = data;
    o.extra   = extra;
    o.fin     = 1'b0;
    return o;
  endfunction

  function automatic logic [7:0] line_base(input logic [1:0] ln);
    logic [7:0] b;
    case (ln)
      2'd0:    b = CMD_LINE0;
      2'd1:    b = CMD_LINE1;
      2'd2:    b = CMD_LINE2;
      default: b = CMD_LINE3;
    endcase
    return b;
  endfunction

  // list of operations for one request
  function automatic void build_ops(input req_t r, input logic four,
                                    output op_t list [OPS_MAX],
                                    output logic [2:0] n);
    op_t wait_op;
    logic [2:0] k;
    wait_op = '0;
    wait_op.is_wait = 1'b1;
    for (int i = 0; i < OPS_MAX; i++) list[i] = '0;
    n = 3'd0;
    k = 3'd0;
    case (r.mode)
      MODE_INIT: begin
        list[0] = wait_op;
        if (four) begin
          list[1] = byte_op(1'b0, CMD_HOME_4BIT, 1'b0);
          list[2] = byte_op(1'b0, CMD_FUNC_4BIT, 1'b0);
          k = 3'd3;
        end else begin
          list[1] = byte_op(1'b0, CMD_FUNC_8BIT, 1'b0);
          k = 3'd2;
        end
        list[k]         = byte_op(1'b0, CMD_DISP_ON, 1'b0);
        list[k + 3'd1]  = byte_op(1'b0, CMD_CLEAR, 1'b1);
        list[k + 3'd2]  = byte_op(1'b0, CMD_ENTRY, 1'b0);
        n = k + 3'd3;
      end
      MODE_CHAR: begin
        list[0] = byte_op(1'b1, r.char_code, 1'b0);
        n = 3'd1;
      end
      MODE_CLEAR: begin
        list[0] = byte_op(1'b0, CMD_CLEAR, 1'b1);
        n = 3'd1;
      end
      MODE_GOTO: begin
        if (r.line[2] == 1'b0) begin
          list[0] = byte_op(1'b0, line_base(r.line[1:0]) + {2'b00, r.column}, 1'b0);
          n = 3'd1;
        end
      end
      MODE_GLYPH: begin
        if (r.glyph_row == 3'd0) begin
          list[0] = byte_op(1'b0, CMD_CGRAM + {2'b00, r.glyph_slot, 3'b000}, 1'b0);
          k = 3'd1;
        end
        list[k] = byte_op(1'b1, r.row_bits, 1'b0);
        k = k + 3'd1;
        if (r.glyph_row == LAST_ROW) begin
          list[k] = byte_op(1'b0, CMD_LINE0, 1'b0);
          k = k + 3'd1;
        end
        n = k;
      end
      default: n = 3'd0;
    endcase
  endfunction

endpackage

// ----- rtl/core/lcdseq_front.sv -----
module lcdseq_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   four_bit_bus,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lcdseq_pkg::req_t       in_item,
  input  lcdseq_pkg::q_status_t  q_status,
  output logic                   push,
  output lcdseq_pkg::op_t        push_op
);
  import lcdseq_pkg::*;

  logic       busy;
  logic [2:0] idx;
  req_t       req;
  op_t        ops [OPS_MAX];
  logic [2:0] n_ops;
  logic       done;

  // pick the current operation of the held request
  always_comb begin
    build_ops(req, four_bit_bus, ops, n_ops);
    push_op     = ops[idx];
    push_op.fin = (idx == n_ops - 3'd1);
    push        = busy && (n_ops != 3'd0) && !q_status.full;
    done        = busy && ((n_ops == 3'd0) || (push && push_op.fin));
    in_ready    = !busy || done;
  end

  // request capture and operation index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (in_valid && in_ready) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (push) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_item;
    end
  end

endmodule

// ----- rtl/core/lcdseq_queue.sv -----
`include "assert_macros.svh"

module lcdseq_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lcdseq_pkg::op_t        push_op,
  input  logic                   pop,
  output lcdseq_pkg::op_t        head,
  output lcdseq_pkg::q_status_t  status
);
  import lcdseq_pkg::*;

  localparam logic [QCNT_W-1:0] CNT_DEPTH = QCNT_W'(QUEUE_DEPTH);

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = (count == CNT_DEPTH);
  assign status.empty = (count == '0);

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && status.full)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && status.empty)
  `ASSERT_AT(a_count_range, clk, rst, count <= CNT_DEPTH)
  `ASSERT_AT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + QCNT_W'(1)))

endmodule

// ----- rtl/core/lcdseq_back.sv -----
module lcdseq_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   four_bit_bus,
  input  lcdseq_pkg::op_t        head,
  input  lcdseq_pkg::q_status_t  q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lcdseq_pkg::phase_t     out_item
);
  import lcdseq_pkg::*;

  logic [1:0] ph;
  logic       final_ph;
  logic       emit;
  phase_t     phase;
  logic [7:0] nib;

  // phase of the head operation
  always_comb begin
    final_ph = head.is_wait || (four_bit_bus ? (ph == 2'd3) : (ph == 2'd1));
    nib      = ph[1] ? {head.data[3:0], 4'b0000} : {head.data[7:4], 4'b0000};
    if (head.is_wait) begin
      phase.reg_select = 1'b0;
      phase.bus_value  = 8'h00;
      phase.enable     = 1'b0;
      phase.hold_ms    = STARTUP_HOLD;
    end else begin
      phase.reg_select = head.rs;
      phase.bus_value  = four_bit_bus ? nib : head.data;
      phase.enable     = !ph[0];
      phase.hold_ms    = (final_ph && head.extra) ? CLEAR_HOLD : PULSE_HOLD;
    end
    phase.last = head.fin && final_ph;
    emit       = !q_status.empty && (!out_valid || out_ready);
    pop        = emit && final_ph;
  end

  // phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= 2'd0;
    end else if (pop) begin
      ph <= 2'd0;
    end else if (emit) begin
      ph <= ph + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= phase;
    end
  end

endmodule

// ----- rtl/core/char_lcd_bus_sequencer.sv -----
// character lcd bus sequencer
// in channel (in_valid/in_ready/in_item) takes one request item: init, write
// character, clear, goto or glyph row. out channel (out_valid/out_ready/
// out_item) gives bus phases: register select, data byte, enable level and
// hold time in ms, with last set on the final phase of each request.
// cfg_we/cfg_wdata write four_bit_bus (1 = nibble bus), resets to 1;
// write it only while the block is idle.
// the front unit expands a request into bus operations, one per cycle while
// the queue has room, into a four-entry queue; the back unit turns each
// operation into 1, 2 or 4 phases, one per cycle while the receiver is ready,
// into the output register.
// throughput: one phase per cycle while the receiver is ready; a request has
// as many phases as its operations give (4 for a typical request on the 4-bit
// bus, up to 21 for init), and the back unit's phase rate sets the pace.
// requests giving no phases (bad goto line, unused mode) are dropped.
// reset clears the queue, the output register and the front unit.
// when the receiver stalls the output holds, the queue fills and then in_ready
// drops until room frees up.
module char_lcd_bus_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcdseq_pkg::req_t    in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdseq_pkg::phase_t  out_item
);
  import lcdseq_pkg::*;

  logic      four_bit_bus;
  logic      push;
  logic      pop;
  op_t       push_op;
  op_t       head;
  q_status_t q_status;

  // bus width register
  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_bus <= 1'b1;
    end else if (cfg_we) begin
      four_bit_bus <= cfg_wdata;
    end
  end

  lcdseq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .four_bit_bus (four_bit_bus),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .q_status     (q_status),
    .push         (push),
    .push_op      (push_op)
  );

  lcdseq_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  lcdseq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .four_bit_bus (four_bit_bus),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item)
  );

endmodule
